// ----- src/mlfq_pkg.sv -----
// Shared types and constants for the multilevel feedback queue scheduler.
package mlfq_pkg;
  localparam int MaxProcs  = 16;
  localparam int MaxLevels = 4;
  localparam int PidW = $clog2(MaxProcs);
  localparam int LvlW = $clog2(MaxLevels);

  localparam logic [1:0] ST_RAN      = 2'd0;
  localparam logic [1:0] ST_IDLE     = 2'd1;
  localparam logic [1:0] ST_REGISTER = 2'd2;
  localparam logic [1:0] ST_REJECT   = 2'd3;

  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_TICK     = 1'b1;

  localparam logic [2:0] REG_NUM_LEVELS = 3'd0;
  localparam logic [2:0] REG_QUANTUM0   = 3'd1;
  localparam logic [2:0] REG_QUANTUM1   = 3'd2;
  localparam logic [2:0] REG_QUANTUM2   = 3'd3;
  localparam logic [2:0] REG_QUANTUM3   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_REG, S_SCAN, S_PICK, S_RUN, S_DONE
  } state_t;

  typedef struct packed {
    logic do_reg;
    logic scan_clear;
    logic scan_step;
    logic pick;
    logic run;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
  } stat_t;
endpackage

// ----- src/mlfq_ctrl.sv -----
// Controller state machine for the scheduler.
module mlfq_ctrl
  import mlfq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  op,
  input  stat_t stat,
  output logic  busy,
  output cmd_t  cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = (op == OP_TICK) ? S_SCAN : S_REG;
      S_REG:  state_next = S_DONE;
      S_SCAN: if (stat.scan_last) state_next = S_PICK;
      S_PICK: state_next = S_RUN;
      S_RUN:  state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE: cmd.scan_clear = 1'b1;
      S_REG:  cmd.do_reg = 1'b1;
      S_SCAN: cmd.scan_step = 1'b1;
      S_PICK: cmd.pick = 1'b1;
      S_RUN:  cmd.run = 1'b1;
      S_DONE: cmd.emit = 1'b1;
      default: cmd = '0;
    endcase
  end
endmodule

// ----- src/mlfq_dp.sv -----
// Datapath: process table, level queues, clock and result register.
module mlfq_dp
  import mlfq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] arrival,
  input  logic [15:0] burst,
  input  logic [2:0]  num_levels,
  input  logic [7:0]  quantum [MaxLevels],
  output stat_t       stat,
  output logic        done,
  output logic [1:0]  status,
  output logic [4:0]  proc_id,
  output logic [1:0]  level,
  output logic        first_run,
  output logic        finished,
  output logic [31:0] time_now
);
  logic [15:0] arr_q, bur_q;
  logic [15:0] p_arr  [MaxProcs];
  logic [15:0] p_rem  [MaxProcs];
  logic [7:0]  p_lt   [MaxProcs];
  logic [MaxProcs-1:0] p_queued, p_started;
  logic [PidW:0] total;
  logic [PidW-1:0] fifo [MaxLevels][MaxProcs];
  logic [PidW-1:0] head [MaxLevels];
  logic [PidW:0]   fill [MaxLevels];
  logic [31:0] clock_time;
  logic [PidW-1:0] scan_idx;
  logic [PidW-1:0] cur_p;
  logic [LvlW-1:0] cur_lvl;
  logic            cur_any;
  logic [LvlW-1:0] sel_lvl;
  logic            sel_any;
  logic [15:0] rem_dec;
  logic [7:0]  lt_inc, q_eff;
  logic [LvlW-1:0] target, lvl_last;
  logic [2:0] nl_c;

  assign stat.scan_last = (scan_idx == PidW'(MaxProcs - 1));

  always_comb begin
    sel_any = 1'b0;
    sel_lvl = '0;
    for (int l = MaxLevels - 1; l >= 0; l--) begin
      if (fill[l] != '0) begin
        sel_any = 1'b1;
        sel_lvl = LvlW'(l);
      end
    end
  end

  assign rem_dec = p_rem[cur_p] - 16'd1;
  assign lt_inc  = (p_lt[cur_p] == 8'hFF) ? 8'hFF : p_lt[cur_p] + 8'd1;
  assign q_eff   = (quantum[cur_lvl] == 8'd0) ? 8'd1 : quantum[cur_lvl];
  always_comb begin
    nl_c = num_levels;
    if (nl_c == 3'd0) nl_c = 3'd1;
    if (32'(nl_c) > MaxLevels) nl_c = 3'(MaxLevels);
    lvl_last = LvlW'(nl_c - 3'd1);
    target = ({1'b0, cur_lvl} < {1'b0, lvl_last}) ? cur_lvl + LvlW'(1) : cur_lvl;
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      arr_q <= arrival;
      bur_q <= burst;
    end
    if (cmd.do_reg && bur_q != 16'd0 && total < (PidW+1)'(MaxProcs)) begin
      p_arr[total[PidW-1:0]] <= arr_q;
      p_rem[total[PidW-1:0]] <= bur_q;
      p_lt[total[PidW-1:0]]  <= 8'd0;
    end
    if (cmd.scan_step && {1'b0, scan_idx} < total && !p_queued[scan_idx]
        && p_rem[scan_idx] != 16'd0 && {16'd0, p_arr[scan_idx]} <= clock_time)
      fifo[0][PidW'(head[0] + fill[0][PidW-1:0])] <= scan_idx;
    if (cmd.pick) begin
      cur_p   <= fifo[sel_lvl][head[sel_lvl]];
      cur_lvl <= sel_lvl;
      cur_any <= sel_any;
    end
    if (cmd.run && cur_any) begin
      p_rem[cur_p] <= rem_dec;
      if (rem_dec != 16'd0 && lt_inc >= q_eff) begin
        p_lt[cur_p] <= 8'd0;
        if (target == cur_lvl)
          fifo[target][PidW'(head[target] + fill[target][PidW-1:0])] <= cur_p;
        else
          fifo[target][PidW'(head[target] + fill[target][PidW-1:0])] <= cur_p;
      end else begin
        p_lt[cur_p] <= lt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_queued <= '0;
      p_started <= '0;
      total <= '0;
      clock_time <= '0;
      scan_idx <= '0;
      done <= 1'b0;
      for (int l = 0; l < MaxLevels; l++) begin
        head[l] <= '0;
        fill[l] <= '0;
      end
    end else begin
      done <= cmd.emit;
      if (cmd.scan_clear) scan_idx <= '0;
      if (cmd.do_reg) begin
        first_run <= 1'b0;
        finished <= 1'b0;
        level <= '0;
        if (bur_q != 16'd0 && total < (PidW+1)'(MaxProcs)) begin
          p_queued[total[PidW-1:0]] <= 1'b0;
          p_started[total[PidW-1:0]] <= 1'b0;
          total <= total + 1'b1;
          status <= ST_REGISTER;
          proc_id <= 5'(total) + 5'd1;
        end else begin
          status <= ST_REJECT;
          proc_id <= '0;
        end
        time_now <= clock_time;
      end
      if (cmd.scan_step) begin
        scan_idx <= scan_idx + 1'b1;
        if ({1'b0, scan_idx} < total && !p_queued[scan_idx]
            && p_rem[scan_idx] != 16'd0 && {16'd0, p_arr[scan_idx]} <= clock_time) begin
          p_queued[scan_idx] <= 1'b1;
          fill[0] <= fill[0] + 1'b1;
        end
      end
      if (cmd.run) begin
        clock_time <= clock_time + 32'd1;
        time_now <= clock_time + 32'd1;
        if (!cur_any) begin
          status <= ST_IDLE;
          proc_id <= '0;
          level <= '0;
          first_run <= 1'b0;
          finished <= 1'b0;
        end else begin
          status <= ST_RAN;
          proc_id <= 5'(cur_p) + 5'd1;
          level <= 2'(cur_lvl);
          first_run <= !p_started[cur_p];
          p_started[cur_p] <= 1'b1;
          finished <= (rem_dec == 16'd0);
          if (rem_dec == 16'd0) begin
            head[cur_lvl] <= head[cur_lvl] + 1'b1;
            fill[cur_lvl] <= fill[cur_lvl] - 1'b1;
          end else if (lt_inc >= q_eff) begin
            head[cur_lvl] <= head[cur_lvl] + 1'b1;
            if (target != cur_lvl) begin
              fill[cur_lvl] <= fill[cur_lvl] - 1'b1;
              fill[target] <= fill[target] + 1'b1;
            end
          end
        end
      end
    end
  end
endmodule

// ----- src/multilevel_feedback_queue_scheduler_unit.sv -----
// Top level of the multilevel feedback queue scheduler.
// Usage:
//  - Command channel: raise start with op, arrival, burst; the
//    word is taken at an edge where start is high and busy is low.
//  - op register: stores a process (zero burst or full table rejected).
//  - op tick: admits arrived processes to level 0 in id order, then runs
//    the front of the lowest-numbered non-empty level for one time unit.
//  - Each command yields one result word, shown for one cycle with done.
//    The receiver cannot stall; nothing is held back.
//  - Sequence: a register command passes through the REG and DONE
//    states; a tick scans the 16 table entries, one per cycle, then
//    passes through the PICK, RUN and DONE states.
//  - Only one command is in flight; busy stays high until done.
//  - Config channel: cfg_valid/cfg_ready (always high), cfg_index and
//    cfg_data; write only while idle, which the block does not enforce.
//  - Reset (rst, synchronous): empty table and queues, time 0, three
//    levels, all quanta 2.
module multilevel_feedback_queue_scheduler_unit
  import mlfq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [15:0] arrival,
  input  logic [15:0] burst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [4:0]  proc_id,
  output logic [1:0]  level,
  output logic        first_run,
  output logic        finished,
  output logic [31:0] time_now
);
  cmd_t  cmd;
  stat_t stat;
  logic [2:0] num_levels;
  logic [7:0] quantum [MaxLevels];

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_levels <= 3'd3;
      for (int l = 0; l < MaxLevels; l++) quantum[l] <= 8'd2;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NUM_LEVELS: num_levels <= cfg_data[2:0];
        REG_QUANTUM0:   quantum[0] <= cfg_data;
        REG_QUANTUM1:   quantum[1] <= cfg_data;
        REG_QUANTUM2:   quantum[2] <= cfg_data;
        REG_QUANTUM3:   quantum[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  mlfq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .op(op), .stat(stat),
    .busy(busy), .cmd(cmd)
  );

  mlfq_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .start(start), .busy(busy),
    .arrival(arrival), .burst(burst),
    .num_levels(num_levels), .quantum(quantum), .stat(stat),
    .done(done), .status(status), .proc_id(proc_id), .level(level),
    .first_run(first_run), .finished(finished), .time_now(time_now)
  );
endmodule

// ----- src/mlfq_checker.sv -----
// Port-level checker for the scheduler, bound to the top level.
module mlfq_checker
  import mlfq_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [4:0]  proc_id,
  input logic        first_run,
  input logic        finished
);
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised");
  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy during done");
  a_ran_id: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_RAN |-> proc_id != 5'd0) else $error("ran without id");
  a_idle_flags: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_RAN |-> !first_run && !finished) else $error("flags");
endmodule

bind multilevel_feedback_queue_scheduler_unit mlfq_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .proc_id(proc_id), .first_run(first_run),
  .finished(finished)
);

// ----- tb/sv/tb_multilevel_feedback_queue_scheduler_unit.sv -----
// Self-checking testbench for the multilevel feedback queue scheduler unit.
module tb_multilevel_feedback_queue_scheduler_unit;
  import mlfq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Config index past the last register: a write there must change nothing.
  localparam logic [2:0] REG_SPARE = 3'd7;
  localparam int TickLatency = 20;   // worst-case accept-to-done wait for a tick
  localparam int StallLimit  = 5000; // cycles with no accepted word before giving up
  localparam int PhaseItems  = 215;
  localparam int NumPhases   = 6;

  typedef struct packed {
    logic [1:0]  st;
    logic [4:0]  pid;
    logic [1:0]  lv;
    logic        fr;
    logic        fin;
    logic [31:0] tnow;
  } sched_word_t;

  typedef struct packed {
    logic        op;
    logic [15:0] arr;
    logic [15:0] bur;
    logic        typed;    // expected word given below instead of the predictor's
    sched_word_t want;
  } cmd_row_t;

  logic        clk, rst;
  logic        start, busy, op;
  logic [15:0] arrival, burst;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        done;
  logic [1:0]  status;
  logic [4:0]  proc_id;
  logic [1:0]  level;
  logic        first_run, finished;
  logic [31:0] time_now;

  multilevel_feedback_queue_scheduler_unit i_dut (
    .clk, .rst, .start, .busy, .op, .arrival, .burst,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .done, .status, .proc_id, .level, .first_run, .finished, .time_now
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- scheduler shadow state ----------------
  logic [2:0]  lvl_count_reg;
  logic [7:0]  quantum_reg [MaxLevels];
  logic [15:0] arrive_at [MaxProcs];
  logic [15:0] left_units [MaxProcs];
  logic [7:0]  units_here [MaxProcs];
  logic        queued_now [MaxProcs];
  logic        has_run [MaxProcs];
  int          table_used;
  int          ready_q [MaxLevels][MaxProcs];
  int          ready_head [MaxLevels];
  int          ready_fill [MaxLevels];
  logic [31:0] sim_clock;

  sched_word_t pending_words [$];
  int          error_count;
  int          n_ran, n_idle, n_reg, n_rej, n_cfg;
  bit          allow_gaps;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  task automatic shadow_reset();
    lvl_count_reg = 3'd3;
    for (int l = 0; l < MaxLevels; l++) begin
      quantum_reg[l] = 8'd2;
      ready_head[l]  = 0;
      ready_fill[l]  = 0;
    end
    for (int p = 0; p < MaxProcs; p++) begin
      queued_now[p] = 1'b0;
      has_run[p]  = 1'b0;
    end
    table_used = 0;
    sim_clock  = '0;
  endtask

  task automatic shadow_config(input logic [2:0] idx, input logic [7:0] data);
    case (idx)
      REG_NUM_LEVELS: lvl_count_reg = data[2:0];
      REG_QUANTUM0:   quantum_reg[0] = data;
      REG_QUANTUM1:   quantum_reg[1] = data;
      REG_QUANTUM2:   quantum_reg[2] = data;
      REG_QUANTUM3:   quantum_reg[3] = data;
      default: ;
    endcase
  endtask

  task automatic ready_push(input int l, input int p);
    if (ready_fill[l] < MaxProcs) begin
      ready_q[l][(ready_head[l] + ready_fill[l]) % MaxProcs] = p;
      ready_fill[l]++;
    end
  endtask

  task automatic ready_pop(input int l);
    if (ready_fill[l] > 0) begin
      ready_head[l] = (ready_head[l] + 1) % MaxProcs;
      ready_fill[l]--;
    end
  endtask

  // One scheduler step: register a process or run one time unit.
  task automatic schedule_step(input logic cmd, input logic [15:0] arr,
                               input logic [15:0] bur, output sched_word_t w);
    int l, p, used, tgt, q;
    w = '0;
    if (cmd == OP_REGISTER) begin
      if (bur == 0 || table_used >= MaxProcs) begin
        w.st = ST_REJECT;
      end else begin
        p = table_used;
        arrive_at[p]  = arr;
        left_units[p] = bur;
        units_here[p] = 8'd0;
        queued_now[p] = 1'b0;
        has_run[p]    = 1'b0;
        table_used++;
        w.st  = ST_REGISTER;
        w.pid = 5'(p + 1);
      end
    end else begin
      for (p = 0; p < table_used; p++)
        if (!queued_now[p] && left_units[p] != 0 && {16'd0, arrive_at[p]} <= sim_clock) begin
          ready_push(0, p);
          queued_now[p] = 1'b1;
        end
      for (l = 0; l < MaxLevels; l++)
        if (ready_fill[l] > 0) break;
      sim_clock++;
      if (l >= MaxLevels) begin
        w.st = ST_IDLE;
      end else begin
        p = ready_q[l][ready_head[l]];
        w.st  = ST_RAN;
        w.pid = 5'(p + 1);
        w.lv  = 2'(l);
        w.fr  = !has_run[p];
        has_run[p] = 1'b1;
        left_units[p]--;
        if (units_here[p] != 8'hFF) units_here[p]++;
        q = (quantum_reg[l] == 0) ? 1 : quantum_reg[l];
        used = (lvl_count_reg == 0) ? 1 : (lvl_count_reg > MaxLevels) ? MaxLevels
                                                                       : lvl_count_reg;
        if (left_units[p] == 0) begin
          ready_pop(l);
          w.fin = 1'b1;
        end else if (units_here[p] >= q) begin
          // demote, or requeue at the back when already at/below the last level in use
          tgt = (l + 1 < used) ? l + 1 : l;
          ready_pop(l);
          units_here[p] = 8'd0;
          ready_push(tgt, p);
        end
      end
    end
    w.tnow = sim_clock;
  endtask

  // ---------------- result checker and watchdog ----------------
  int quiet_cycles;
  always @(posedge clk) begin
    if (!rst) begin
      sched_word_t w;
      quiet_cycles <= ((start && !busy) || done) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("watchdog: no word accepted for %0d cycles", StallLimit);
        $display("CHECKS FAILED");
        $finish;
      end else if (done) begin
        if (pending_words.size() == 0) begin
          error_count++;
          $display("[%0t] result word with nothing expected", $realtime);
        end else begin
          w = pending_words.pop_front();
          if (status !== w.st)
            report_mismatch("status", 32'(status), 32'(w.st));
          if (proc_id !== w.pid)
            report_mismatch("proc_id", 32'(proc_id), 32'(w.pid));
          if (level !== w.lv)
            report_mismatch("level", 32'(level), 32'(w.lv));
          if (first_run !== w.fr)
            report_mismatch("first_run", 32'(first_run), 32'(w.fr));
          if (finished !== w.fin)
            report_mismatch("finished", 32'(finished), 32'(w.fin));
          if (time_now !== w.tnow)
            report_mismatch("time_now", time_now, w.tnow);
          case (w.st)
            ST_RAN:      n_ran++;
            ST_IDLE:     n_idle++;
            ST_REGISTER: n_reg++;
            default:     n_rej++;
          endcase
        end
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  // ---------------- drivers ----------------
  // Present one command word; inputs move only on the falling edge.
  task automatic send_word(input logic cmd, input logic [15:0] arr, input logic [15:0] bur,
                           input logic typed, input sched_word_t want);
    sched_word_t w;
    if (allow_gaps && $urandom_range(99) < 35) begin
      start = 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
    start = 1'b1;
    op = cmd;
    arrival = arr;
    burst = bur;
    do @(posedge clk); while (busy);
    schedule_step(cmd, arr, bur, w);
    pending_words.insert(pending_words.size(), typed ? want : w);
    @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    // a word in flight may still be finishing; let the worst-case latency pass
    repeat (TickLatency + 5) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    shadow_config(idx, data);
    n_cfg++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // directed rows: typed words are plain to read off the scheduling rules
  cmd_row_t directed [] = '{
    '{OP_REGISTER, 16'd0,     16'd0,     1'b1, '{ST_REJECT,   5'd0, 2'd0, 1'b0, 1'b0, 32'd0}},
    '{OP_TICK,     16'hFFFF,  16'hFFFF,  1'b1, '{ST_IDLE,     5'd0, 2'd0, 1'b0, 1'b0, 32'd1}},
    '{OP_REGISTER, 16'd0,     16'd1,     1'b1, '{ST_REGISTER, 5'd1, 2'd0, 1'b0, 1'b0, 32'd1}},
    '{OP_TICK,     16'd0,     16'd0,     1'b1, '{ST_RAN,      5'd1, 2'd0, 1'b1, 1'b1, 32'd2}},
    '{OP_REGISTER, 16'hFFFF,  16'hFFFF,  1'b1, '{ST_REGISTER, 5'd2, 2'd0, 1'b0, 1'b0, 32'd2}},
    '{OP_REGISTER, 16'd0,     16'hFFFF,  1'b1, '{ST_REGISTER, 5'd3, 2'd0, 1'b0, 1'b0, 32'd2}},
    '{OP_REGISTER, 16'd3,     16'd5,     1'b0, '0},
    '{OP_REGISTER, 16'd1,     16'd2,     1'b0, '0},   // late arrival, admitted next tick
    '{OP_TICK,     16'h5555,  16'hAAAA,  1'b0, '0},
    '{OP_TICK,     16'hAAAA,  16'h5555,  1'b0, '0},
    '{OP_TICK,     16'd0,     16'd0,     1'b0, '0},
    '{OP_TICK,     16'd0,     16'd0,     1'b0, '0},
    '{OP_TICK,     16'd0,     16'd0,     1'b0, '0},
    '{OP_TICK,     16'd0,     16'd0,     1'b0, '0},
    '{OP_TICK,     16'd0,     16'd0,     1'b0, '0},
    '{OP_TICK,     16'd0,     16'd0,     1'b0, '0},
    '{OP_TICK,     16'd0,     16'd0,     1'b0, '0},
    '{OP_TICK,     16'd0,     16'd0,     1'b0, '0},
    '{OP_TICK,     16'd0,     16'd0,     1'b0, '0},
    '{OP_TICK,     16'd0,     16'd0,     1'b0, '0}
  };

  // register settings per random phase: levels, quantum 0..3 (extremes included)
  logic [7:0] phase_cfg [NumPhases][5] = '{
    '{8'd1, 8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd4, 8'd255, 8'd255, 8'd255, 8'd255},
    '{8'd0, 8'd1,   8'd3,   8'd0,   8'd7},
    '{8'd7, 8'd2,   8'd1,   8'd1,   8'd1},
    '{8'd2, 8'd5,   8'd0,   8'd2,   8'd4},
    '{8'd3, 8'd1,   8'd2,   8'd3,   8'd4}
  };

  initial begin
    logic        cmd;
    logic [15:0] arr, bur;
    int          pick;
    rst = 1'b1;
    start = 1'b0;
    op = OP_TICK;
    arrival = '0;
    burst = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    error_count = 0;
    n_ran = 0; n_idle = 0; n_reg = 0; n_rej = 0; n_cfg = 0;
    allow_gaps = 1'b1;
    shadow_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part runs with reset settings
    foreach (directed[k])
      send_word(directed[k].op, directed[k].arr, directed[k].bur,
                directed[k].typed, directed[k].want);

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      write_reg(REG_NUM_LEVELS, phase_cfg[ph][0]);
      write_reg(REG_QUANTUM0, phase_cfg[ph][1]);
      write_reg(REG_QUANTUM1, phase_cfg[ph][2]);
      write_reg(REG_QUANTUM2, phase_cfg[ph][3]);
      write_reg(REG_QUANTUM3, phase_cfg[ph][4]);
      write_reg(REG_SPARE, 8'($urandom));   // spare index, no effect
      // one phase runs back to back with no gaps at all
      allow_gaps = (ph != 2);
      for (int k = 0; k < PhaseItems; k++) begin
        pick = $urandom_range(99);
        if (pick < 20) begin
          cmd = OP_REGISTER;
          // arrivals cluster around the current time so processes really compete
          arr = 16'(sim_clock) + 16'($urandom_range(0, 40)) - 16'd10;
          pick = $urandom_range(99);
          bur = (pick < 85) ? 16'($urandom_range(1, 12))
              : (pick < 95) ? 16'($urandom) : 16'd0;
          if ($urandom_range(19) == 0) arr = 16'($urandom);
        end else begin
          cmd = OP_TICK;
          arr = 16'($urandom);
          bur = 16'($urandom);
        end
        send_word(cmd, arr, bur, 1'b0, '0);
      end
    end

    drain();
    $display("covered %0d run, %0d idle, %0d registered, %0d rejected words",
             n_ran, n_idle, n_reg, n_rej);
    $display("across %0d register writes and %0d setting phases", n_cfg, NumPhases);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", error_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
